// ===== rtl/core/isoeci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoeci_pkg
// Shared widths, word types and codes of the edge crossing interpolator.
// ----------------------------------------------------------------------------
package isoeci_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 16;

	// sample minus iso level
	localparam int YW  = SAMPLE_BITS + 1;
	// end-to-end difference and linear operands
	localparam int LW  = SAMPLE_BITS + 2;
	// quadratic, linear and constant terms of the fit (scaled by 4)
	localparam int AW  = SAMPLE_BITS + 3;
	localparam int BW  = SAMPLE_BITS + 5;
	localparam int CW  = SAMPLE_BITS + 3;
	localparam int EW  = BW + 1;
	// discriminant and squared terms
	localparam int DW  = 2 * BW;
	localparam int EEW = 2 * EW;
	// square root: result bits and radicand width
	localparam int RW  = SAMPLE_BITS + FRACTION_BITS + 6;
	localparam int XW  = 2 * RW;
	// signed numerator, unsigned dividend, divisor
	localparam int NW  = SAMPLE_BITS + FRACTION_BITS + 8;
	localparam int NUW = NW - 1;
	localparam int DVW = SAMPLE_BITS + 5;
	// quotient bits and output fraction width
	localparam int QW  = FRACTION_BITS + 2;
	localparam int OW  = FRACTION_BITS + 1;

	localparam logic [OW-1:0] FRAC_ONE = OW'(1) << FRACTION_BITS;

	localparam logic REG_ISO  = 1'b0;
	localparam logic REG_QUAD = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NEG_DISC  = 2'd1,
		ST_SATURATED = 2'd2,
		ST_ZERO_DEN  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_before;
		logic signed [SAMPLE_BITS-1:0] sample_start;
		logic signed [SAMPLE_BITS-1:0] sample_end;
		logic signed [SAMPLE_BITS-1:0] sample_after;
		logic                          has_before;
		logic                          has_after;
	} in_word_t;

	typedef struct packed {
		logic [OW-1:0] crossing_fraction;
		status_t       status;
	} out_word_t;

	// result that overrides the divider when spec is set
	typedef struct packed {
		logic          spec;
		logic [OW-1:0] frac;
		status_t       st;
	} tail_t;

	typedef struct packed {
		tail_t                 tail;
		logic                  lin;
		logic                  small_root;
		logic signed [NW-1:0]  base;
		logic [NUW-1:0]        nlin;
		logic [DVW-1:0]        dv;
	} solve_t;

	typedef struct packed {
		logic [NUW-1:0] n;
		logic [DVW-1:0] dv;
		tail_t          tail;
	} div_in_t;

endpackage

// ===== rtl/core/isoeci_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoeci_front
// Six-stage front end: iso offset, fit terms, products, discriminant and
// classification of the degenerate and saturated cases.
// ----------------------------------------------------------------------------
module isoeci_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  isoeci_pkg::in_word_t                  in_word,
	input  logic signed [isoeci_pkg::SAMPLE_BITS-1:0] iso,
	input  logic                                  quad,
	output logic                                  valid,
	output logic [isoeci_pkg::XW-1:0]             x,
	output isoeci_pkg::solve_t                    pay
);
	import isoeci_pkg::*;

	localparam int SB = SAMPLE_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic signed [YW-1:0] iso_e, yb_c, ys_c, ye_c, ya_c;
	logic signed [YW-1:0] y0_s1, y1_s1, y2_s1, y3_s1;
	logic                 quad_s1;

	assign iso_e = $signed({iso[SB-1], iso});
	assign yb_c  = $signed({in_word.sample_before[SB-1], in_word.sample_before}) - iso_e;
	assign ys_c  = $signed({in_word.sample_start[SB-1], in_word.sample_start}) - iso_e;
	assign ye_c  = $signed({in_word.sample_end[SB-1], in_word.sample_end}) - iso_e;
	assign ya_c  = $signed({in_word.sample_after[SB-1], in_word.sample_after}) - iso_e;

	// stage 2
	logic signed [AW-1:0] a_s2;
	logic signed [LW-1:0] d21_s2;
	logic signed [YW-1:0] y1_s2;
	logic                 quad_s2;

	// stage 3
	logic signed [BW-1:0] b_c;
	logic signed [CW-1:0] c_c;
	logic signed [AW-1:0] an_s3;
	logic signed [BW-1:0] bn_s3;
	logic signed [CW-1:0] cn_s3;
	logic                 lin_s3;
	logic signed [LW-1:0] lden_s3, lnum_s3;

	assign b_c = (BW'(d21_s2) <<< 2) - BW'(a_s2);
	assign c_c = CW'(y1_s2) <<< 2;

	// stage 4
	logic signed [DW-1:0]    bb_s4;
	logic signed [AW+CW-1:0] acp_s4;
	logic signed [EW-1:0]    e_s4;
	logic signed [AW-1:0]    an_s4;
	logic signed [BW-1:0]    bn_s4;
	logic                    lin_s4;
	tail_t                   ltail_c, ltail_s4;
	logic [NUW-1:0]          nlin_s4;
	logic [DVW-1:0]          dvlin_s4;

	always_comb begin
		ltail_c = '{spec: 1'b0, frac: '0, st: ST_OK};
		if (lden_s3 == '0) begin
			ltail_c = '{spec: 1'b1, frac: '0, st: ST_ZERO_DEN};
		end else if (lnum_s3[LW-1]) begin
			ltail_c = '{spec: 1'b1, frac: '0, st: ST_SATURATED};
		end else if (lnum_s3 > lden_s3) begin
			ltail_c = '{spec: 1'b1, frac: FRAC_ONE, st: ST_SATURATED};
		end
	end

	// stage 5
	logic signed [DW-1:0]  d_s5, bb_s5;
	logic signed [EEW-1:0] ee_s5;
	logic                  bpos_s5, eneg_s5, lin_s5;
	logic signed [NW-1:0]  base_s5;
	logic [DVW-1:0]        dvq_s5, dvlin_s5;
	tail_t                 ltail_s5;
	logic [NUW-1:0]        nlin_s5;

	// stage 6: classify
	logic [EEW-1:0] d_u, bb_u, ee_u;
	logic           small_c;
	tail_t          qtail_c;
	solve_t         pay_c, pay_s6;
	logic [XW-1:0]  x_c, x_s6;

	assign d_u     = EEW'($unsigned(d_s5));
	assign bb_u    = EEW'($unsigned(bb_s5));
	assign ee_u    = $unsigned(ee_s5);
	assign small_c = eneg_s5 || (ee_u < d_u);
	assign x_c     = XW'(d_s5[DW-2:0]) << (2 * FRACTION_BITS + 2);

	always_comb begin
		qtail_c = '{spec: 1'b0, frac: '0, st: ST_OK};
		if (d_s5[DW-1]) begin
			qtail_c = '{spec: 1'b1, frac: '0, st: ST_NEG_DISC};
		end else if (bpos_s5 && (d_u < bb_u)) begin
			qtail_c = '{spec: 1'b1, frac: '0, st: ST_SATURATED};
		end else if (eneg_s5 && (d_u < ee_u)) begin
			qtail_c = '{spec: 1'b1, frac: FRAC_ONE, st: ST_SATURATED};
		end else if (small_c && (bpos_s5 || (bb_u < d_u))) begin
			qtail_c = '{spec: 1'b1, frac: '0, st: ST_SATURATED};
		end
		pay_c.tail       = lin_s5 ? ltail_s5 : qtail_c;
		pay_c.lin        = lin_s5;
		pay_c.small_root = small_c;
		pay_c.base       = base_s5;
		pay_c.nlin       = nlin_s5;
		pay_c.dv         = lin_s5 ? dvlin_s5 : dvq_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y1_s1    <= ys_c;
			y2_s1    <= ye_c;
			y0_s1    <= in_word.has_before ? yb_c : ys_c;
			y3_s1    <= in_word.has_after ? ya_c : ye_c;
			quad_s1  <= quad;

			a_s2     <= AW'(y0_s1) - AW'(y1_s1) - AW'(y2_s1) + AW'(y3_s1);
			d21_s2   <= LW'(y2_s1) - LW'(y1_s1);
			y1_s2    <= y1_s1;
			quad_s2  <= quad_s1;

			// flip signs so the quadratic term is positive
			an_s3    <= a_s2[AW-1] ? -a_s2 : a_s2;
			bn_s3    <= a_s2[AW-1] ? -b_c : b_c;
			cn_s3    <= a_s2[AW-1] ? -c_c : c_c;
			lin_s3   <= !quad_s2 || (a_s2 == '0);
			lden_s3  <= d21_s2[LW-1] ? -d21_s2 : d21_s2;
			lnum_s3  <= d21_s2[LW-1] ? LW'(y1_s2) : -LW'(y1_s2);

			bb_s4    <= bn_s3 * bn_s3;
			acp_s4   <= an_s3 * cn_s3;
			e_s4     <= (EW'(an_s3) <<< 1) + EW'(bn_s3);
			an_s4    <= an_s3;
			bn_s4    <= bn_s3;
			lin_s4   <= lin_s3;
			ltail_s4 <= ltail_c;
			nlin_s4  <= (NUW'(lnum_s3[LW-2:0]) << (FRACTION_BITS + 1))
				+ NUW'(lden_s3[LW-2:0]);
			dvlin_s4 <= DVW'(lden_s3[LW-2:0]) << 1;

			d_s5     <= bb_s4 - (DW'(acp_s4) <<< 2);
			ee_s5    <= e_s4 * e_s4;
			bb_s5    <= bb_s4;
			bpos_s5  <= !bn_s4[BW-1] && (bn_s4 != '0);
			eneg_s5  <= e_s4[EW-1];
			base_s5  <= (NW'(an_s4) <<< 1) - (NW'(bn_s4) <<< (FRACTION_BITS + 1));
			dvq_s5   <= DVW'(an_s4[AW-2:0]) << 2;
			dvlin_s5 <= dvlin_s4;
			lin_s5   <= lin_s4;
			ltail_s5 <= ltail_s4;
			nlin_s5  <= nlin_s4;

			pay_s6   <= pay_c;
			x_s6     <= x_c;
		end
	end

	assign valid = v_s6;
	assign x     = x_s6;
	assign pay   = pay_s6;

endmodule

// ===== rtl/core/isoeci_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoeci_sqrt
// Pipelined restoring square root, one result bit per stage, with an
// exactness flag from the final remainder.
// ----------------------------------------------------------------------------
module isoeci_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [isoeci_pkg::XW-1:0]     x,
	input  isoeci_pkg::solve_t            in_pay,
	output logic                          valid,
	output logic [isoeci_pkg::RW-1:0]     root,
	output logic                          exact,
	output isoeci_pkg::solve_t            pay
);
	import isoeci_pkg::*;

	logic            vld_s  [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [XW-1:0]   xs_s   [RW];
	solve_t          pay_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic          vi;
		logic [XW-1:0] xi;
		logic [RW+1:0] ri, cur, trial;
		logic [RW-1:0] qi;
		solve_t        pi;
		logic          ge;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign xi = x;
			assign ri = '0;
			assign qi = '0;
			assign pi = in_pay;
		end else begin : g_next
			assign vi = vld_s[k-1];
			assign xi = xs_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = root_s[k-1];
			assign pi = pay_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign cur   = {ri[RW-1:0], xi[XW-1 -: 2]};
		assign trial = {qi, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? cur - trial : cur;
				root_s[k] <= {qi[RW-2:0], ge};
				xs_s[k]   <= xi << 2;
				pay_s[k]  <= pi;
			end
		end
	end

	assign valid = vld_s[RW-1];
	assign root  = root_s[RW-1];
	assign exact = (rem_s[RW-1] == '0);
	assign pay   = pay_s[RW-1];

endmodule

// ===== rtl/core/isoeci_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoeci_div
// Pipelined restoring divider: an overflow check stage, then one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module isoeci_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  isoeci_pkg::div_in_t         din,
	output logic                        valid,
	output logic [isoeci_pkg::QW-1:0]   quo,
	output logic                        ovf,
	output isoeci_pkg::tail_t           tail
);
	import isoeci_pkg::*;

	localparam int NS = QW + 1;

	logic           vld_s  [NS];
	logic [NUW-1:0] rem_s  [NS];
	logic [QW-1:0]  quo_s  [NS];
	logic           ovf_s  [NS];
	logic [DVW-1:0] dv_s   [NS];
	tail_t          tail_s [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// quotient would need more than QW bits: saturate later
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= din.n;
			quo_s[0]  <= '0;
			ovf_s[0]  <= din.n >= (NUW'(din.dv) << QW);
			dv_s[0]   <= din.dv;
			tail_s[0] <= din.tail;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_st
		localparam int SH = QW - j;
		logic [NUW-1:0] trial;
		logic           ge;

		assign trial = NUW'(dv_s[j-1]) << SH;
		assign ge    = rem_s[j-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? rem_s[j-1] - trial : rem_s[j-1];
				quo_s[j]  <= {quo_s[j-1][QW-2:0], ge};
				ovf_s[j]  <= ovf_s[j-1];
				dv_s[j]   <= dv_s[j-1];
				tail_s[j] <= tail_s[j-1];
			end
		end
	end

	assign valid = vld_s[NS-1];
	assign quo   = quo_s[NS-1];
	assign ovf   = ovf_s[NS-1];
	assign tail  = tail_s[NS-1];

endmodule

// ===== rtl/core/isosurface_edge_crossing_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isosurface_edge_crossing_interpolator
// Iso level crossing along a grid edge, linear or least-squares quadratic,
// as an unsigned Q1.16 fraction with a status code.
// ----------------------------------------------------------------------------
//
//  port group | dir | handshake        | carries
//  -----------+-----+------------------+----------------------------------
//  in_*       | in  | in_valid/in_stall   | four samples and two present flags
//  out_*      | out | out_valid/out_stall | crossing fraction and status
//  APB        | in  | psel/penable     | iso_value (0x0), quadratic_mode (0x4)
//
//  One word enters per cycle unless the pipeline is stalled; each word passes through
//  6 front stages, RW = 38 square root stages, 1 numerator stage,
//  QW + 1 = 19 divider stages and 1 output stage.
//  The square root pipeline, one root bit per stage, sets the depth.
//  A stalled output word freezes the whole pipeline; in_stall then rises.
//  Reset clears the valid bits only; registers return to iso 0, quadratic.
//
module isosurface_edge_crossing_interpolator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  isoeci_pkg::in_word_t  in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output isoeci_pkg::out_word_t out_word,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import isoeci_pkg::*;

	// configuration registers
	logic signed [SAMPLE_BITS-1:0] iso_q;
	logic                          quad_q;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q  <= '0;
			quad_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ISO:  iso_q  <= pwdata[SAMPLE_BITS-1:0];
				REG_QUAD: quad_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ISO:  prdata = 32'($signed(iso_q));
			REG_QUAD: prdata = {31'd0, quad_q};
			default:  prdata = '0;
		endcase
	end

	// global advance: hold everything while the output word waits
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// front end: offsets, fit terms, discriminant, special cases
	logic          fr_valid;
	logic [XW-1:0] fr_x;
	solve_t        fr_pay;

	isoeci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_word  (in_word),
		.iso      (iso_q),
		.quad     (quad_q),
		.valid    (fr_valid),
		.x        (fr_x),
		.pay      (fr_pay)
	);

	// square root of the scaled discriminant
	logic          sq_valid;
	logic [RW-1:0] sq_root;
	logic          sq_exact;
	solve_t        sq_pay;

	isoeci_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.x        (fr_x),
		.in_pay   (fr_pay),
		.valid    (sq_valid),
		.root     (sq_root),
		.exact    (sq_exact),
		.pay      (sq_pay)
	);

	// numerator: larger root adds the floor root, smaller root subtracts
	// the ceiling; a negative numerator gives a zero quotient
	logic signed [NW-1:0] num_c, sel_c;
	logic                 v_s7;
	div_in_t              din_c, din_s7;

	always_comb begin
		if (sq_pay.small_root) begin
			num_c = sq_pay.base - (NW'(sq_root) + NW'(!sq_exact));
		end else begin
			num_c = sq_pay.base + NW'(sq_root);
		end
		sel_c       = sq_pay.lin ? NW'(sq_pay.nlin) : num_c;
		din_c.n     = sel_c[NW-1] ? '0 : sel_c[NUW-1:0];
		din_c.dv    = sq_pay.dv;
		din_c.tail  = sq_pay.tail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			din_s7 <= din_c;
		end
	end

	// divide by 4a (quadratic) or 2*den (linear)
	logic          dv_valid;
	logic [QW-1:0] dv_quo;
	logic          dv_ovf;
	tail_t         dv_tail;

	isoeci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.din      (din_s7),
		.valid    (dv_valid),
		.quo      (dv_quo),
		.ovf      (dv_ovf),
		.tail     (dv_tail)
	);

	// output stage: special cases win, else clamp the quotient to 1.0
	logic      v_s8;
	out_word_t res_c, res_s8;

	always_comb begin
		if (dv_tail.spec) begin
			res_c.crossing_fraction = dv_tail.frac;
			res_c.status            = dv_tail.st;
		end else begin
			if (dv_ovf || (dv_quo > QW'(FRAC_ONE))) begin
				res_c.crossing_fraction = FRAC_ONE;
			end else begin
				res_c.crossing_fraction = dv_quo[OW-1:0];
			end
			res_c.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8 <= res_c;
		end
	end

	assign out_valid = v_s8;
	assign out_word  = res_s8;

endmodule

// ===== rtl/core/isoeci_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoeci_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module isoeci_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input isoeci_pkg::out_word_t out_word
);
	import isoeci_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("output word changed while stalled");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.crossing_fraction <= FRAC_ONE)
		else $error("fraction above one");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == ST_NEG_DISC || out_word.status == ST_ZERO_DEN)
		|-> out_word.crossing_fraction == '0)
		else $error("failed solve with nonzero fraction");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind isosurface_edge_crossing_interpolator isoeci_checker u_isoeci_checker (.*);
